// File: sv/sha1_pkg.sv
// sha1_pkg: constants, types and round helpers shared by the sha-1 hasher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sha1_pkg;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hefcdab89;
	localparam logic [31:0] H2 = 32'h98badcfe;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hc3d2e1f0;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	// one queued item between the front and the back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} item_t;

	function automatic logic [31:0] round_const(input logic [6:0] t);
		logic [31:0] k;
		begin
			if (t < 7'd20)      k = 32'h5a827999;
			else if (t < 7'd40) k = 32'h6ed9eba1;
			else if (t < 7'd60) k = 32'h8f1bbcdc;
			else                k = 32'hca62c1d6;
			return k;
		end
	endfunction

	function automatic logic [31:0] round_fn(input logic [6:0] t, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		begin
			if (t < 7'd20)      f = (b & c) ^ (~b & d);
			else if (t < 7'd40) f = b ^ c ^ d;
			else if (t < 7'd60) f = (b & c) ^ (b & d) ^ (c & d);
			else                f = b ^ c ^ d;
			return f;
		end
	endfunction

endpackage
`default_nettype wire

// File: sv/sha1_front.sv
// sha1_front: two-entry input item queue
// depends on sha1_pkg
`timescale 1ns / 1ps
`default_nettype none
module sha1_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire sha1_pkg::item_t in_item,
	output logic                 q_valid,
	input  wire                  q_ready,
	output sha1_pkg::item_t      q_item
);
	import sha1_pkg::*;

	item_t      mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	// items with neither flag do nothing, drop them here
	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready && (in_item.byte_present || in_item.end_of_message);
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// File: sv/sha1_back.sv
// sha1_back: byte packing, padding, 80-round compression and digest output
// depends on sha1_pkg
`timescale 1ns / 1ps
`default_nettype none
module sha1_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  q_valid,
	output logic                 q_ready,
	input  wire sha1_pkg::item_t q_item,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [31:0]          digest_word,
	output logic [2:0]           word_index,
	output logic                 last_word
);
	import sha1_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_ROUND = 6'b000100,
		ST_ADD   = 6'b001000,
		ST_LEN   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t      state_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [63:0] count_q;
	logic [6:0]  round_q;
	logic        fin_q;      // compression is part of the final padding
	logic        len_q;      // the length words are in the current block
	logic [2:0]  idx_q;

	logic [5:0]  pos;
	logic [3:0]  wsel;
	logic [31:0] w_new, w_cur, tmp;
	logic [63:0] bits;

	assign pos  = count_q[5:0];
	assign wsel = pos[5:2];
	assign bits = {count_q[60:0], 3'b000};

	// the schedule lives in a 16-word window shifted once per round
	assign w_new = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
		w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
	assign w_cur = (round_q < 7'd16) ? w_q[0] : w_new;
	assign tmp = {a_q[26:0], a_q[31:27]} + round_fn(round_q, b_q, c_q, d_q) + e_q
		+ round_const(round_q) + w_cur;

	assign q_ready     = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_EMIT);
	assign digest_word = h_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd4);

	function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] sel,
		input logic [7:0] v);
		logic [31:0] r;
		begin
			r = w;
			case (sel)
				2'd0: r = {v, 24'd0};
				2'd1: r[23:16] = v;
				2'd2: r[15:8] = v;
				2'd3: r[7:0] = v;
				default: r = w;
			endcase
			return r;
		end
	endfunction

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (q_valid && q_item.byte_present)
				w_q[wsel] <= put_byte(w_q[wsel], pos[1:0], q_item.data_byte);
			ST_PAD: begin
				w_q[wsel] <= put_byte(w_q[wsel], pos[1:0], PAD_BYTE);
				for (int i = 0; i < 16; i++)
					if (4'(i) > wsel) w_q[i] <= 32'd0;
			end
			ST_LEN: begin
				for (int i = 0; i < 14; i++)
					if (!len_q) w_q[i] <= 32'd0;
				w_q[14] <= bits[63:32];
				w_q[15] <= bits[31:0];
			end
			ST_ROUND: begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= w_cur;
				a_q <= tmp;
				b_q <= a_q;
				c_q <= {b_q[1:0], b_q[31:2]};
				d_q <= c_q;
				e_q <= d_q;
			end
			default: ;
		endcase
		if (state_q != ST_ROUND && state_q != ST_ADD && state_q != ST_EMIT) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
			count_q <= 64'd0;
			round_q <= 7'd0;
			fin_q   <= 1'b0;
			len_q   <= 1'b0;
			idx_q   <= 3'd0;
		end else begin
			case (state_q)
				ST_IDLE: if (q_valid) begin
					if (q_item.byte_present) count_q <= count_q + 64'd1;
					fin_q <= q_item.end_of_message;
					if (q_item.byte_present && pos == 6'd63) state_q <= ST_ROUND;
					else if (q_item.end_of_message) state_q <= ST_PAD;
				end
				ST_PAD: begin
					fin_q <= 1'b1;
					// no room for the length words: one extra block
					if (pos > 6'd55) begin
						len_q <= 1'b0;
						state_q <= ST_ROUND;
					end else begin
						len_q <= 1'b1;
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					len_q <= 1'b1;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					round_q <= round_q + 7'd1;
					if (round_q == 7'd79) begin
						round_q <= 7'd0;
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					if (!fin_q) state_q <= ST_IDLE;
					else if (len_q) state_q <= ST_EMIT;
					// the block-filling byte also ended the message: pad a fresh block
					else if (pos == 6'd0) state_q <= ST_PAD;
					else state_q <= ST_LEN;
				end
				ST_EMIT: if (out_ready) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd4) begin
						idx_q <= 3'd0;
						h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
						count_q <= 64'd0;
						fin_q <= 1'b0;
						len_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sv/sha1_message_hasher_top.sv
// sha1_message_hasher_top: sha-1 hasher taking one message byte per transfer
// depends on sha1_pkg, sha1_front, sha1_back
`timescale 1ns / 1ps
`default_nettype none
// SHA-1 over a byte stream. Each transfer carries one optional byte; the transfer
// with end_of_message set pads the message and returns the five digest words, index 0
// first, as five output transfers. A byte that completes a 64-byte block starts its
// compression in the single round unit (80 rounds and the chaining add), and the back
// end takes no further items until it is done. The end of message costs one or two
// further blocks, the PAD and LEN states and five output transfers. A two-entry queue
// in front accepts up to two input transfers while the round unit is busy.
module sha1_message_hasher_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire [7:0]   data_byte,
	input  wire         byte_present,
	input  wire         end_of_message,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha1_pkg::*;

	item_t in_item, q_item;
	logic  q_valid, q_ready;

	assign in_item = '{data_byte: data_byte, byte_present: byte_present,
		end_of_message: end_of_message};

	sha1_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	sha1_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_item(q_item), .out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// tb_top: self-checking testbench for sha1_message_hasher_top, with a sha-1 predictor
// depends on sha1_pkg and sha1_message_hasher_top
`timescale 1ns / 1ps
module tb_top;
	import sha1_pkg::*;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_exp_t;

	logic        clk = 0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        byte_present;
	logic        end_of_message;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha1_message_hasher_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .byte_present(byte_present),
		.end_of_message(end_of_message),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	// predictor state
	logic [31:0] hash_chain [5];
	logic [31:0] msg_block [16];
	logic [63:0] byte_total;
	digest_exp_t digest_q[$];

	int  mismatches = 0;
	int  stall_pct = 13;
	bit  rx_hold = 0;
	int  idle_cycles = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void sha1_compress();
		logic [31:0] a, b, c, d, e, f, k, w, t;
		a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2];
		d = hash_chain[3]; e = hash_chain[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 16) w = msg_block[r];
			else begin
				w = rotl(msg_block[(r + 13) & 15] ^ msg_block[(r + 8) & 15]
					^ msg_block[(r + 2) & 15] ^ msg_block[r & 15], 1);
				msg_block[r & 15] = w;
			end
			if (r < 20) begin f = (b & c) ^ (~b & d); k = 32'h5a827999; end
			else if (r < 40) begin f = b ^ c ^ d; k = 32'h6ed9eba1; end
			else if (r < 60) begin f = (b & c) ^ (b & d) ^ (c & d); k = 32'h8f1bbcdc; end
			else begin f = b ^ c ^ d; k = 32'hca62c1d6; end
			t = rotl(a, 5) + f + e + k + w;
			e = d; d = c; c = rotl(b, 30); b = a; a = t;
		end
		hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c;
		hash_chain[3] += d; hash_chain[4] += e;
	endfunction

	function automatic void pack_byte(input int pos, input logic [7:0] v);
		int w;
		w = (pos >> 2) & 15;
		if ((pos & 3) == 0) msg_block[w] = {v, 24'h0};
		else msg_block[w] |= 32'(v) << (24 - 8 * (pos & 3));
	endfunction

	function automatic void hash_restart();
		hash_chain[0] = H0; hash_chain[1] = H1; hash_chain[2] = H2;
		hash_chain[3] = H3; hash_chain[4] = H4;
		byte_total = 0;
	endfunction

	function automatic void hash_absorb(input logic [7:0] b, input logic p, input logic eom);
		int pos;
		digest_exp_t x;
		if (p) begin
			pos = int'(byte_total[5:0]);
			pack_byte(pos, b);
			byte_total++;
			if (pos == 63) sha1_compress();
		end
		if (!eom) return;
		pos = int'(byte_total[5:0]);
		pack_byte(pos, PAD_BYTE);
		for (int i = (pos >> 2) + 1; i < 16; i++) msg_block[i] = 0;
		if (pos > 55) begin
			sha1_compress();
			for (int i = 0; i < 16; i++) msg_block[i] = 0;
		end
		msg_block[14] = byte_total[60:29];
		msg_block[15] = {byte_total[28:0], 3'b000};
		sha1_compress();
		for (int i = 0; i < 5; i++) begin
			x.word = hash_chain[i];
			x.idx = 3'(i);
			x.last = (i == 4);
			digest_q.push_back(x);
		end
		hash_restart();
	endfunction

	// valid stays up between items; it drops only while idling
	task automatic send_item(input logic [7:0] b, input logic p, input logic eom);
		while (($urandom_range(99) < stall_pct)) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		data_byte <= b;
		byte_present <= p;
		end_of_message <= eom;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		hash_absorb(b, p, eom);
	endtask

	task automatic send_message(input int len, input bit gaps);
		for (int i = 0; i < len; i++) begin
			if (gaps && $urandom_range(15) == 0) send_item(8'($urandom), 0, 0);
			send_item(8'($urandom), 1, 0);
		end
		if ($urandom_range(1)) send_item(8'($urandom), 1, 1);
		else send_item(8'($urandom), 0, 1);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (digest_q.size() != 0) @(posedge clk);
	endtask

	// directed: empty message, flags, field extremes
	task automatic test_directed();
		send_item(8'h00, 0, 1);
		send_item(8'hff, 0, 0);
		send_item(8'hff, 1, 0);
		send_item(8'h00, 1, 0);
		send_item(8'h55, 1, 1);
		send_item(8'haa, 1, 1);
	endtask

	// lengths around the one/two final-block split and a byte that fills the block
	task automatic test_pad_boundaries();
		int lens[4] = '{55, 56, 63, 64};
		foreach (lens[i]) begin
			for (int j = 0; j < lens[i] - 1; j++) send_item(8'($urandom), 1, 0);
			send_item(8'($urandom), 1, 1);
		end
	endtask

	task automatic test_random_messages();
		int n;
		n = 0;
		while (n < 140) begin
			int len;
			len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(20);
			send_message(len, 1);
			n += len + 1;
		end
	endtask

	// receiver stalls long while the sender keeps offering items
	task automatic test_backpressure();
		rx_hold = 1;
		for (int m = 0; m < 4; m++) send_message($urandom_range(3), 0);
		in_valid <= 0;
		wait (!rx_hold);
		wait_drained();
	endtask

	task automatic test_no_idle();
		stall_pct = 0;
		for (int m = 0; m < 4; m++) send_message($urandom_range(40), 0);
		stall_pct = 13;
	endtask

	// receiver side
	always @(posedge clk) begin
		if (!arst_n) out_ready <= 0;
		else out_ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
	end

	initial begin
		wait (rx_hold);
		repeat (400) @(posedge clk);
		rx_hold = 0;
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected digest transfer %h idx %0d", digest_word, word_index);
			end else begin
				digest_exp_t x;
				x = digest_q.pop_front();
				if (digest_word !== x.word || word_index !== x.idx || last_word !== x.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
							x.word, x.idx, x.last, digest_word, word_index, last_word);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		data_byte = 0;
		byte_present = 0;
		end_of_message = 0;
		out_ready = 0;
		hash_restart();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_pad_boundaries();
		wait_drained();
		test_backpressure();
		test_no_idle();
		test_random_messages();
		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && digest_q.size() == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule

// File: files.f
sv/sha1_pkg.sv
sv/sha1_front.sv
sv/sha1_back.sv
sv/sha1_message_hasher_top.sv
verif/tb_top.sv
